// ===== rtl/core/kvfl_pkg.sv =====
package kvfl_pkg;

  localparam int ADDR_W     = 48;
  localparam int ROW_W      = 16;
  localparam int STRIDE_W   = 21;
  localparam int NUM_W      = 13;
  localparam int ACT_W      = 6;
  localparam int CHAN_W     = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int ROW_SHIFT  = 20;
  localparam int START_W    = ADDR_W - ROW_SHIFT + 1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADCH = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// ===== rtl/core/kv_cache_free_list_allocator_core.sv =====
// Accept reads the list memory and moves to S_EXEC, where the update runs and busy is high;
// no new request is taken before the update. done is registered from exec. Init runs through
// the same states: filled entries read as base + i*stride (flat) or start + i (row) until
// overwritten, so no fill pass runs.
// Reset (rst, synchronous) clears pointers, counts, state and config registers to defaults;
// the list memories are not cleared. done cannot be stalled by the receiver.
module kv_cache_free_list_allocator_core
  import kvfl_pkg::*;
#(
  parameter int FLAT_ENTRIES  = 4096,
  parameter int CHANNELS      = 32,
  parameter int ROWS_PER_BANK = 32768
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [CHAN_W-1:0]     channel,
  input  logic [ADDR_W-1:0]     free_value,
  output logic                  done,
  output logic [ADDR_W-1:0]     alloc_value,
  output logic [1:0]            status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int FI_W   = (FLAT_ENTRIES > 1) ? $clog2(FLAT_ENTRIES) : 1;
  localparam int FC_W   = $clog2(FLAT_ENTRIES + 1);
  localparam int RI_W   = $clog2(ROWS_PER_BANK);
  localparam int RC_W   = $clog2(ROWS_PER_BANK + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NV_W   = $clog2(CHANNELS + 1) > ACT_W ? $clog2(CHANNELS + 1) : ACT_W;
  localparam int PROD_W = FI_W + STRIDE_W;
  localparam int ROW_DEPTH = CHANNELS * (2 ** RI_W);

  state_t state, state_next;
  logic   exec;

  logic                cfg_mode;
  logic [ADDR_W-1:0]   cfg_base;
  logic [STRIDE_W-1:0] cfg_stride;
  logic [NUM_W-1:0]    cfg_num;
  logic [ACT_W-1:0]    cfg_active;

  logic [1:0]          req_q;
  logic [CHAN_W-1:0]   ch_q;
  logic [ADDR_W-1:0]   fval_q;

  logic [ADDR_W-1:0]   flat_mem [FLAT_ENTRIES];
  logic [ADDR_W-1:0]   flat_rdata;
  logic [FI_W-1:0]     flat_head;
  logic [FI_W-1:0]     flat_tail;
  logic [FC_W-1:0]     flat_count;
  logic [FC_W-1:0]     flat_ovw;
  logic [FC_W-1:0]     flat_n;
  logic [ADDR_W-1:0]   base_l;
  logic [STRIDE_W-1:0] stride_l;
  logic [PROD_W-1:0]   prod_full;
  logic [ADDR_W-1:0]   flat_prod;

  logic [ROW_W-1:0]    row_mem [ROW_DEPTH];
  logic [ROW_W-1:0]    row_rdata;
  logic [RI_W-1:0]     row_head  [CHANNELS];
  logic [RI_W-1:0]     row_tail  [CHANNELS];
  logic [RC_W-1:0]     row_count [CHANNELS];
  logic [RC_W-1:0]     row_ovw   [CHANNELS];
  logic [CHANNELS-1:0] row_filled;
  logic [RC_W-1:0]     row_n;
  logic [ROW_W-1:0]    start_l;

  logic                accept;
  logic [CH_W-1:0]     ch_in;
  logic [CH_W-1:0]     ch_c;
  logic [NV_W-1:0]     nvalid;
  logic                ch_ok;

  logic [FC_W-1:0]     f_head_ext;
  logic                f_fresh;
  logic [ADDR_W-1:0]   f_value;
  logic [RI_W-1:0]     r_head;
  logic [RC_W-1:0]     r_head_ext;
  logic                r_fresh;
  logic [ROW_W-1:0]    r_value;
  logic                f_full;
  logic                r_full;

  logic                do_init;
  logic                pop_f, push_f, pop_r, push_r;
  logic [1:0]          res_status;
  logic [ADDR_W-1:0]   res_value;

  logic [FC_W-1:0]     init_fn;
  logic [START_W-1:0]  row_start;
  logic [RC_W-1:0]     init_rn;

  assign accept = start && !busy;
  assign ch_in  = CH_W'(channel);
  assign ch_c   = CH_W'(ch_q);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state)
      S_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode   <= 1'b0;
      cfg_base   <= '0;
      cfg_stride <= STRIDE_W'(1);
      cfg_num    <= '0;
      cfg_active <= ACT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   cfg_mode   <= cfg_wdata[0];
        CFG_BASE:   cfg_base   <= cfg_wdata[ADDR_W-1:0];
        CFG_STRIDE: cfg_stride <= cfg_wdata[STRIDE_W-1:0];
        CFG_NUM:    cfg_num    <= cfg_wdata[NUM_W-1:0];
        CFG_ACTIVE: cfg_active <= cfg_wdata[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  assign prod_full = PROD_W'(flat_head) * PROD_W'(stride_l);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q     <= req_type;
      ch_q      <= channel;
      fval_q    <= free_value;
      flat_prod <= ADDR_W'(prod_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flat_rdata <= flat_mem[flat_head];
    end
    if (push_f) begin
      flat_mem[flat_tail] <= fval_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_rdata <= row_mem[{ch_in, row_head[ch_in]}];
    end
    if (push_r) begin
      row_mem[{ch_c, row_tail[ch_c]}] <= fval_q[ROW_W-1:0];
    end
  end

  always_comb begin
    nvalid = (NV_W'(cfg_active) < NV_W'(CHANNELS)) ? NV_W'(cfg_active) : NV_W'(CHANNELS);
    ch_ok  = NV_W'(ch_q) < nvalid;

    f_head_ext = FC_W'(flat_head);
    f_fresh    = (f_head_ext >= flat_ovw) && (f_head_ext < flat_n);
    f_value    = f_fresh ? base_l + flat_prod : flat_rdata;
    f_full     = flat_count == FC_W'(FLAT_ENTRIES);

    r_head     = row_head[ch_c];
    r_head_ext = RC_W'(r_head);
    r_fresh    = row_filled[ch_c] && (r_head_ext >= row_ovw[ch_c]) && (r_head_ext < row_n);
    r_value    = r_fresh ? start_l + ROW_W'(r_head) : row_rdata;
    r_full     = row_count[ch_c] == RC_W'(ROWS_PER_BANK);

    init_fn   = ({{(32-NUM_W){1'b0}}, cfg_num} < 32'(FLAT_ENTRIES))
                ? FC_W'(cfg_num) : FC_W'(FLAT_ENTRIES);
    row_start = START_W'(cfg_base[ADDR_W-1:ROW_SHIFT]) + START_W'(1);
    init_rn   = (row_start < START_W'(ROWS_PER_BANK))
                ? RC_W'(START_W'(ROWS_PER_BANK) - row_start) : '0;

    do_init    = 1'b0;
    pop_f      = 1'b0;
    push_f     = 1'b0;
    pop_r      = 1'b0;
    push_r     = 1'b0;
    res_status = ST_OK;
    res_value  = '0;
    if (exec) begin
      case (req_q)
        REQ_INIT: do_init = 1'b1;
        REQ_ALLOC: begin
          if (!cfg_mode) begin
            if (flat_count == '0) begin
              res_status = ST_EMPTY;
            end else begin
              pop_f     = 1'b1;
              res_value = f_value;
            end
          end else if (!ch_ok) begin
            res_status = ST_BADCH;
          end else if (row_count[ch_c] == '0) begin
            res_status = ST_EMPTY;
          end else begin
            pop_r     = 1'b1;
            res_value = ADDR_W'(r_value);
          end
        end
        REQ_FREE: begin
          if (!cfg_mode) begin
            if (f_full) begin
              res_status = ST_FULL;
            end else begin
              push_f = 1'b1;
            end
          end else if (!ch_ok) begin
            res_status = ST_BADCH;
          end else if (r_full) begin
            res_status = ST_FULL;
          end else begin
            push_r = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flat_head  <= '0;
      flat_tail  <= '0;
      flat_count <= '0;
      flat_ovw   <= '0;
      flat_n     <= '0;
    end else if (do_init) begin
      flat_head  <= '0;
      flat_ovw   <= '0;
      if (!cfg_mode) begin
        flat_count <= init_fn;
        flat_n     <= init_fn;
        flat_tail  <= (init_fn == FC_W'(FLAT_ENTRIES)) ? '0 : FI_W'(init_fn);
      end else begin
        flat_count <= '0;
        flat_n     <= '0;
        flat_tail  <= '0;
      end
    end else begin
      if (pop_f) begin
        flat_head  <= (flat_head == FI_W'(FLAT_ENTRIES - 1)) ? '0 : flat_head + FI_W'(1);
        flat_count <= flat_count - FC_W'(1);
      end
      if (push_f) begin
        flat_tail  <= (flat_tail == FI_W'(FLAT_ENTRIES - 1)) ? '0 : flat_tail + FI_W'(1);
        flat_count <= flat_count + FC_W'(1);
        if (FC_W'(flat_tail) == flat_ovw && flat_ovw < flat_n) begin
          flat_ovw <= flat_ovw + FC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_init) begin
      base_l   <= cfg_base;
      stride_l <= cfg_stride;
      start_l  <= ROW_W'(row_start);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_filled <= '0;
      row_n      <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        row_head[c]  <= '0;
        row_tail[c]  <= '0;
        row_count[c] <= '0;
        row_ovw[c]   <= '0;
      end
    end else if (do_init) begin
      row_n <= cfg_mode ? init_rn : '0;
      for (int c = 0; c < CHANNELS; c++) begin
        row_head[c] <= '0;
        row_ovw[c]  <= '0;
        if (cfg_mode && (NV_W'(c) < nvalid)) begin
          row_filled[c] <= 1'b1;
          row_count[c]  <= init_rn;
          row_tail[c]   <= RI_W'(init_rn);
        end else begin
          row_filled[c] <= 1'b0;
          row_count[c]  <= '0;
          row_tail[c]   <= '0;
        end
      end
    end else begin
      if (pop_r) begin
        row_head[ch_c]  <= (r_head == RI_W'(ROWS_PER_BANK - 1)) ? '0 : r_head + RI_W'(1);
        row_count[ch_c] <= row_count[ch_c] - RC_W'(1);
      end
      if (push_r) begin
        row_tail[ch_c]  <= (row_tail[ch_c] == RI_W'(ROWS_PER_BANK - 1))
                           ? '0 : row_tail[ch_c] + RI_W'(1);
        row_count[ch_c] <= row_count[ch_c] + RC_W'(1);
        if (RC_W'(row_tail[ch_c]) == row_ovw[ch_c] && row_ovw[ch_c] < row_n) begin
          row_ovw[ch_c] <= row_ovw[ch_c] + RC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      alloc_value <= res_value;
      status      <= res_status;
    end
  end

endmodule

// ===== rtl/core/kvfl_checker.sv =====
module kvfl_checker
  import kvfl_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [ADDR_W-1:0] alloc_value,
  input logic [1:0]        status
);

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction gave no result two cycles later");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a transaction in progress");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (alloc_value == '0))
    else $error("error result carries a nonzero value");

endmodule

bind kv_cache_free_list_allocator_core kvfl_checker u_kvfl_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .alloc_value (alloc_value),
  .status      (status)
);

// ===== bench/tb.sv =====
import kvfl_pkg::*;

typedef struct packed {
  logic [ADDR_W-1:0] value;
  logic [1:0]        status;
} alloc_result_t;

class kvfl_scoreboard;
  localparam int FLAT_N = 4096;
  localparam int ROW_N  = 32768;
  localparam int CH_N   = 32;

  logic              mode;
  logic [ADDR_W-1:0] base;
  logic [20:0]       stride;
  logic [12:0]       num;
  logic [5:0]        active;

  logic [ADDR_W-1:0] flat_slots [FLAT_N];
  logic [11:0]       flat_head;
  logic [11:0]       flat_tail;
  logic [12:0]       flat_count;

  bit [15:0]         row_freed [int];
  logic [28:0]       row_first;
  logic [14:0]       row_head [CH_N];
  logic [14:0]       row_tail [CH_N];
  logic [15:0]       row_count [CH_N];

  alloc_result_t     awaited_results [$];
  int unsigned       faults;
  int unsigned       req_seen [4];
  int unsigned       status_seen [4];

  function new();
    mode = 1'b0;
    base = '0;
    stride = 21'd1;
    num = '0;
    active = 6'd1;
    row_first = '0;
    faults = 0;
    foreach (req_seen[i]) req_seen[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_lists();
  endfunction

  function void clear_lists();
    flat_head = '0;
    flat_tail = '0;
    flat_count = '0;
    foreach (row_head[c]) begin
      row_head[c] = '0;
      row_tail[c] = '0;
      row_count[c] = '0;
    end
    row_freed.delete();
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_MODE:   mode = data[0];
      CFG_BASE:   base = data[ADDR_W-1:0];
      CFG_STRIDE: stride = data[STRIDE_W-1:0];
      CFG_NUM:    num = data[NUM_W-1:0];
      CFG_ACTIVE: active = data[ACT_W-1:0];
      default: ;
    endcase
  endfunction

  function int usable_channels();
    return (active > CH_N) ? CH_N : int'(active);
  endfunction

  function void refill_lists();
    int n;
    int nch;
    logic [ADDR_W-1:0] addr;
    clear_lists();
    if (!mode) begin
      n = (num > FLAT_N) ? FLAT_N : int'(num);
      addr = base;
      for (int i = 0; i < n; i++) begin
        flat_slots[i] = addr;
        addr = addr + ADDR_W'(stride);
      end
      flat_count = 13'(n);
      flat_tail = 12'(n);
    end else begin
      row_first = 29'(base >> ROW_SHIFT) + 29'd1;
      n = (row_first < ROW_N) ? ROW_N - int'(row_first) : 0;
      nch = usable_channels();
      for (int c = 0; c < nch; c++) begin
        row_count[c] = 16'(n);
        row_tail[c] = 15'(n);
      end
    end
  endfunction

  function void accept_request(logic [1:0] rq, logic [CHAN_W-1:0] ch,
                               logic [ADDR_W-1:0] fv);
    alloc_result_t res;
    int c;
    int key;
    res.value = '0;
    res.status = ST_OK;
    req_seen[rq]++;
    if (rq == REQ_INIT) begin
      refill_lists();
    end else if (rq == REQ_ALLOC || rq == REQ_FREE) begin
      if (!mode) begin
        if (rq == REQ_ALLOC) begin
          if (flat_count == 0) begin
            res.status = ST_EMPTY;
          end else begin
            res.value = flat_slots[flat_head];
            flat_head++;
            flat_count--;
          end
        end else if (flat_count >= FLAT_N) begin
          res.status = ST_FULL;
        end else begin
          flat_slots[flat_tail] = fv;
          flat_tail++;
          flat_count++;
        end
      end else if (int'(ch) >= usable_channels()) begin
        res.status = ST_BADCH;
      end else begin
        c = int'(ch);
        if (rq == REQ_ALLOC) begin
          if (row_count[c] == 0) begin
            res.status = ST_EMPTY;
          end else begin
            key = c * ROW_N + int'(row_head[c]);
            res.value = row_freed.exists(key) ? ADDR_W'(row_freed[key])
                                              : ADDR_W'(16'(row_first + 29'(row_head[c])));
            row_head[c]++;
            row_count[c]--;
          end
        end else if (row_count[c] >= ROW_N) begin
          res.status = ST_FULL;
        end else begin
          key = c * ROW_N + int'(row_tail[c]);
          row_freed[key] = fv[ROW_W-1:0];
          row_tail[c]++;
          row_count[c]++;
        end
      end
    end
    status_seen[res.status]++;
    awaited_results = {awaited_results, res};
  endfunction

  function void note_fault(string what, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
    faults++;
    if (faults <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  function void check_response(logic [ADDR_W-1:0] av, logic [1:0] st);
    alloc_result_t want;
    if (awaited_results.size() == 0) begin
      note_fault("unexpected response", '0, av);
      return;
    end
    want = awaited_results[0];
    awaited_results.delete(0);
    if (av !== want.value) note_fault("alloc_value", want.value, av);
    if (st !== want.status) note_fault("status", ADDR_W'(want.status), ADDR_W'(st));
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_RSVD = 2'd3;
  localparam int RANDOM_ITEMS = 1600;
  localparam int TAIL_ITEMS   = 200;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            req_type = REQ_ALLOC;
  logic [CHAN_W-1:0]     channel = '0;
  logic [ADDR_W-1:0]     free_value = '0;
  logic                  done;
  logic [ADDR_W-1:0]     alloc_value;
  logic [1:0]            status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  kvfl_scoreboard sb;
  int gap_pct;
  int settings;
  logic              cur_mode;
  logic [ADDR_W-1:0] cur_base;
  logic [20:0]       cur_stride;
  logic [5:0]        cur_active;

  kv_cache_free_list_allocator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .channel(channel), .free_value(free_value),
    .done(done), .alloc_value(alloc_value), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_response(alloc_value, status);
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic issue(input logic [1:0] rq, input logic [CHAN_W-1:0] ch,
                       input logic [ADDR_W-1:0] fv);
    int gap;
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(11, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rq;
    channel <= ch;
    free_value <= fv;
    do @(posedge clk); while (busy);
    sb.accept_request(rq, ch, fv);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic program_regs(input logic md, input logic [ADDR_W-1:0] b,
                              input logic [20:0] s, input logic [12:0] n,
                              input logic [5:0] a);
    drain();
    write_reg(CFG_MODE, CFG_DATA_W'(md));
    write_reg(CFG_BASE, CFG_DATA_W'(b));
    write_reg(CFG_STRIDE, CFG_DATA_W'(s));
    write_reg(CFG_NUM, CFG_DATA_W'(n));
    write_reg(CFG_ACTIVE, CFG_DATA_W'(a));
    cfg_we <= 1'b0;
    cur_mode = md;
    cur_base = b;
    cur_stride = s;
    cur_active = a;
    settings++;
  endtask

  initial begin
    int n_random;
    int len;
    int alloc_share;
    int r;
    int u;
    int w;
    logic [4:0] hot;
    logic [1:0] rq;
    logic [CHAN_W-1:0] ch;
    logic [ADDR_W-1:0] fv;
    logic md;
    logic [ADDR_W-1:0] b;
    logic [20:0] s;
    logic [12:0] n;
    logic [5:0] a;

    sb = new();
    settings = 0;
    n_random = 0;
    gap_pct = 30;
    cur_mode = 1'b0;
    cur_base = '0;
    cur_stride = 21'd1;
    cur_active = 6'd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty flat list straight out of reset, reserved type, push and pop
    issue(REQ_ALLOC, 5'd0, '0);
    issue(REQ_RSVD, 5'h1f, ALL_ONES);
    issue(REQ_FREE, 5'h1f, ALL_ONES);
    issue(REQ_ALLOC, 5'h0a, '0);

    // flat addresses wrap past the top of the address space
    program_regs(1'b0, ALL_ONES - 48'd1, 21'd1048576, 13'd3, 6'd1);
    issue(REQ_INIT, 5'd3, '0);
    repeat (4) issue(REQ_ALLOC, 5'($urandom), '0);

    // oversized count clamps to a full list
    program_regs(1'b0, '0, 21'd1, 13'h1fff, 6'd1);
    issue(REQ_INIT, 5'd0, '0);
    issue(REQ_FREE, 5'd0, 48'h5555_5555_5555);
    issue(REQ_ALLOC, 5'd0, '0);

    // zero active channels
    program_regs(1'b1, '0, 21'd1, 13'd0, 6'd0);
    issue(REQ_ALLOC, 5'd0, '0);

    // clamped channel count, nearly full lists, free onto a full list
    program_regs(1'b1, 48'h0f_ffff, 21'd1, 13'd0, 6'h3f);
    issue(REQ_INIT, 5'd0, '0);
    issue(REQ_FREE, 5'd0, ALL_ONES);
    issue(REQ_FREE, 5'd0, ALL_ONES);
    issue(REQ_ALLOC, 5'd31, '0);

    program_regs(1'b1, 48'h0f_ffff, 21'd1, 13'd0, 6'd2);
    issue(REQ_ALLOC, 5'd2, '0);
    issue(REQ_FREE, 5'd5, 48'h1234);

    // single row per channel, then empty
    program_regs(1'b1, 48'(32766) << ROW_SHIFT, 21'd1, 13'd0, 6'd32);
    issue(REQ_INIT, 5'd0, '0);
    issue(REQ_ALLOC, 5'd1, '0);
    issue(REQ_ALLOC, 5'd1, '0);

    // start row past the end of the bank
    program_regs(1'b1, ALL_ONES, 21'd1, 13'd0, 6'd32);
    issue(REQ_INIT, 5'd0, '0);
    issue(REQ_ALLOC, 5'd0, '0);

    while (n_random < RANDOM_ITEMS) begin
      md = 1'($urandom);
      r = $urandom_range(99);
      b = (r < 80) ? rand48() : ((r < 90) ? '0 : ALL_ONES);
      r = $urandom_range(99);
      s = (r < 70) ? 21'($urandom_range(1048576, 1)) : ((r < 85) ? 21'd1 : 21'd1048576);
      r = $urandom_range(99);
      if (r < 50) n = 13'($urandom_range(40));
      else if (r < 75) n = 13'($urandom_range(4096, 4080));
      else if (r < 92) n = 13'($urandom_range(4096));
      else n = 13'($urandom_range(8191, 4097));
      r = $urandom_range(99);
      a = (r < 85) ? 6'($urandom_range(32, 1)) : ((r < 92) ? 6'd0 : 6'($urandom_range(63, 33)));
      if (md) begin
        r = $urandom_range(3);
        if (r == 0) b = 48'($urandom_range(32'h000f_ffff));
        else if (r == 1) b = (48'(32767 - $urandom_range(24)) << ROW_SHIFT) |
                             48'($urandom_range(32'h000f_ffff));
      end
      program_regs(md, b, s, n, a);
      gap_pct = ($urandom_range(3) == 0) ? 0 : 35;
      u = (cur_active > 32) ? 32 : int'(cur_active);
      hot = (u > 0) ? 5'($urandom_range(u - 1)) : 5'd0;
      alloc_share = $urandom_range(75, 25);
      if ($urandom_range(9) != 0) begin
        issue(REQ_INIT, 5'($urandom), rand48());
        n_random++;
      end
      len = $urandom_range(140, 40);
      for (int k = 0; k < len && n_random < RANDOM_ITEMS; k++) begin
        if (n_random >= RANDOM_ITEMS - TAIL_ITEMS) gap_pct = 0;
        r = $urandom_range(99);
        if (r < 2) rq = REQ_RSVD;
        else if (r < 5) rq = REQ_INIT;
        else if (r < 5 + (95 * alloc_share) / 100) rq = REQ_ALLOC;
        else rq = REQ_FREE;
        r = $urandom_range(99);
        if (!cur_mode || u == 0 || r < 10) ch = 5'($urandom);
        else if (r < 75) ch = hot;
        else ch = 5'($urandom_range(u - 1));
        if ($urandom_range(1)) fv = rand48();
        else if (cur_mode) fv = 48'($urandom_range(32767));
        else fv = cur_base + 48'(cur_stride) * 48'($urandom_range(4095));
        issue(rq, ch, fv);
        if (rq != REQ_RSVD) n_random++;
      end
    end

    start <= 1'b0;
    for (w = 0; w < 2000 && sb.awaited_results.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d alloc, %0d free, %0d init, %0d reserved transactions over %0d settings",
             sb.req_seen[REQ_ALLOC], sb.req_seen[REQ_FREE], sb.req_seen[REQ_INIT],
             sb.req_seen[REQ_RSVD], settings);
    $display("responses: %0d ok, %0d empty, %0d full, %0d bad channel; %0d mismatches",
             sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY], sb.status_seen[ST_FULL],
             sb.status_seen[ST_BADCH], sb.faults);
    if (sb.faults == 0 && sb.awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
